// ----- rtl/led_eff_pkg.sv -----
// shared types, codes and constants of the led effect controller
package led_eff_pkg;

  localparam int LED_COUNT_DEF = 8;

  // shared divider widths
  localparam int DVD_W = 24;
  localparam int DVS_W = 16;

  // request codes
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_OFF     = 3'd1;
  localparam logic [2:0] REQ_ON      = 3'd2;
  localparam logic [2:0] REQ_TOGGLE  = 3'd3;
  localparam logic [2:0] REQ_BLINK   = 3'd4;
  localparam logic [2:0] REQ_BREATHE = 3'd5;
  localparam logic [2:0] REQ_MARQUEE = 3'd6;

  // per led effect modes
  localparam logic [1:0] MODE_STATIC  = 2'd0;
  localparam logic [1:0] MODE_BLINK   = 2'd1;
  localparam logic [1:0] MODE_BREATHE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_BLINK   = 3'd0;
  localparam logic [2:0] CFG_BREATHE = 3'd1;
  localparam logic [2:0] CFG_MARQUEE = 3'd2;
  localparam logic [2:0] CFG_FRAME   = 3'd3;
  localparam logic [2:0] CFG_MASK    = 3'd4;

  // configuration reset values
  localparam logic [15:0] BLINK_RST   = 16'd500;
  localparam logic [15:0] BREATHE_RST = 16'd2000;
  localparam logic [15:0] MARQUEE_RST = 16'd200;
  localparam logic [7:0]  FRAME_RST   = 8'd20;
  localparam logic [7:0]  MASK_RST    = 8'd0;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CMD, OP_DIV, OP_BREATHE, OP_CHECK, OP_FIRE_BLINK, OP_FIRE_HW,
    OP_FIRE_OFF, OP_ADVANCE, OP_SAVE_ON, OP_FIRE_ON, OP_NEXT, OP_MARQ_TICK, OP_READ, OP_POP
  } dp_op_t;

  // divider operand selection
  typedef enum logic [1:0] {DIV_STEPS, DIV_LEVEL, DIV_ON, DIV_OFF} div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    div_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_breathe;
    logic fire;
    logic blink;
    logic hw;
    logic onph;
    logic walk_last;
    logic q_empty;
    logic div_done;
  } dp_stat_t;

  // one queued result
  typedef struct packed {
    logic [2:0] id;
    logic       lit;
    logic [6:0] level;
    logic       ann;
    logic [2:0] cause;
    logic       bad;
  } res_t;

endpackage

// ----- rtl/led_effect_controller.sv -----
// top level of the led effect controller
//
// One request at a time: in_ready is high only while the block is idle. A command
// is taken in and decoded; a breathe command also waits for one division of the
// period by the frame length. A tick walks every LED timer in turn, waiting for
// one division on a fire that needs one (a hardware brightness frame or the end
// of a software PWM on phase) and for two on a software PWM frame start; all of
// these use the shared bit-serial divider. Results are then drained from a small
// queue, one per handshake while out_ready is high, since drive_mask reports the
// bits after the whole request.
module led_effect_controller
  import led_eff_pkg::*;
#(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [7:0]  led_index,
  input  logic [15:0] duration_ms,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  led_id,
  output logic        lit,
  output logic [6:0]  level_percent,
  output logic [7:0]  drive_mask,
  output logic        announced,
  output logic [2:0]  cause_code,
  output logic        status,
  output logic        last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     res;
  logic     res_last;

  led_eff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_last  (res_last),
    .stat      (stat),
    .cmd       (cmd)
  );

  led_eff_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (req_type),
    .led_index   (led_index),
    .duration_ms (duration_ms),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .res         (res),
    .res_last    (res_last),
    .drive_mask  (drive_mask)
  );

  // result fields
  assign led_id        = res.id;
  assign lit           = res.lit;
  assign level_percent = res.level;
  assign announced     = res.ann;
  assign cause_code    = res.cause;
  assign status        = res.bad;
  assign last          = res_last;

endmodule

// ----- rtl/led_eff_div.sv -----
// restoring divider, one quotient bit per cycle
module led_eff_div
  import led_eff_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one trial subtraction
  always_comb begin
    trial = {rem, quotient[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(DVD_W);
        rem      <= '0;
        quotient <= dividend;
        dvs      <= divisor;
      end else if (busy) begin
        rem      <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quotient <= {quotient[DVD_W-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/led_eff_dp.sv -----
// datapath: led state, marquee state, configuration, divider and result queue
module led_eff_dp
  import led_eff_pkg::*;
#(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [2:0]  req_type,
  input  logic [7:0]  led_index,
  input  logic [15:0] duration_ms,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output res_t        res,
  output logic        res_last,
  output logic [7:0]  drive_mask
);

  localparam int LIDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int CNT_W  = $clog2(LED_COUNT + 1);

  function automatic logic [15:0] arm(input logic [15:0] p);
    return (p == 16'd0) ? 16'd1 : p;
  endfunction

  // configuration
  logic [15:0] blink_def, breathe_def, marquee_def;
  logic [7:0]  frame_cfg, hw_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_def   <= BLINK_RST;
      breathe_def <= BREATHE_RST;
      marquee_def <= MARQUEE_RST;
      frame_cfg   <= FRAME_RST;
      hw_mask     <= MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLINK:   blink_def   <= cfg_data;
        CFG_BREATHE: breathe_def <= cfg_data;
        CFG_MARQUEE: marquee_def <= cfg_data;
        CFG_FRAME:   frame_cfg   <= cfg_data[7:0];
        CFG_MASK:    hw_mask     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // request and per led state
  logic [2:0]          req_q;
  logic [7:0]          idx_q;
  logic [15:0]         per_q;
  logic [LIDX_W-1:0]   sel;
  logic [1:0]          mode   [LED_COUNT];
  logic [15:0]         period [LED_COUNT];
  logic [15:0]         step   [LED_COUNT];
  logic [15:0]         total  [LED_COUNT];
  logic [15:0]         cd     [LED_COUNT];
  logic [LED_COUNT-1:0] mon, drive, rising, onph;
  logic                mq_active;
  logic [LIDX_W-1:0]   mq_pos;
  logic [15:0]         mq_period;
  logic [15:0]         mq_cd;
  logic                fire_q;
  logic [15:0]         on_q;
  logic [CNT_W-1:0]    wptr, rptr;

  // current led view
  logic [1:0]  cur_mode;
  logic [15:0] cur_step, cur_total, cur_cd, cur_period;
  logic        cur_mon, cur_drive, cur_rising, cur_onph;
  logic [7:0]  sel8;
  logic        idx_bad;
  logic [7:0]  frame;
  logic [15:0] steps, den, q16, lvl16;
  logic [6:0]  lvl;
  logic        t_on, t_off, mq_fire;
  logic [LIDX_W-1:0] mq_next, idx_l;
  logic [15:0] pe_marq, pe_blink, pe_breathe;
  logic [15:0] adv_step;
  logic        adv_rising;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic        div_done;
  logic        push;
  res_t        push_res;
  logic [LED_COUNT+7:0] drive_pad;

  always_comb begin
    cur_mode   = mode[sel];
    cur_step   = step[sel];
    cur_total  = total[sel];
    cur_cd     = cd[sel];
    cur_period = period[sel];
    cur_mon    = mon[sel];
    cur_drive  = drive[sel];
    cur_rising = rising[sel];
    cur_onph   = onph[sel];
    sel8       = 8'(sel);
    idx_l      = idx_q[LIDX_W-1:0];
    idx_bad    = 9'(idx_q) >= 9'(LED_COUNT);
    frame      = (frame_cfg == 8'd0) ? 8'd1 : frame_cfg;
    steps      = (cur_total == 16'd0) ? 16'd1 : cur_total;
    den        = (steps > 16'd1) ? steps - 16'd1 : 16'd1;
    q16        = div_q[15:0];
    lvl16      = (div_q > DVD_W'(100)) ? 16'd100 : q16;
    lvl        = lvl16[6:0];
    t_on       = !cur_mon && (req_q == REQ_ON || req_q == REQ_TOGGLE);
    t_off      = cur_mon && (req_q == REQ_OFF || req_q == REQ_TOGGLE);
    mq_fire    = mq_active && (mq_cd == 16'd1);
    mq_next    = (mq_pos == LIDX_W'(LED_COUNT - 1)) ? '0 : mq_pos + 1'b1;
    pe_marq    = (per_q != 16'd0) ? per_q : marquee_def;
    pe_blink   = (per_q != 16'd0) ? per_q : blink_def;
    pe_breathe = (per_q != 16'd0) ? per_q : breathe_def;
  end

  // ramp walk one step up or down
  always_comb begin
    adv_step   = cur_step;
    adv_rising = cur_rising;
    if (cur_rising) begin
      if (cur_step + 16'd1 >= cur_total || cur_step == 16'hFFFF) begin
        adv_step   = (cur_total != 16'd0) ? cur_total - 16'd1 : 16'd0;
        adv_rising = 1'b0;
      end else begin
        adv_step = cur_step + 16'd1;
      end
    end else if (cur_step == 16'd0) begin
      adv_rising = 1'b1;
    end else begin
      adv_step = cur_step - 16'd1;
    end
  end

  // divider operands
  always_comb begin
    case (cmd.sel)
      DIV_STEPS: begin
        div_dvd = DVD_W'(pe_breathe);
        div_dvs = DVS_W'(frame);
      end
      DIV_LEVEL: begin
        div_dvd = DVD_W'(cur_step) * DVD_W'(100);
        div_dvs = den;
      end
      DIV_ON: begin
        div_dvd = DVD_W'(cur_step) * DVD_W'(frame);
        div_dvs = steps;
      end
      default: begin
        div_dvd = DVD_W'(steps - cur_step) * DVD_W'(frame);
        div_dvs = steps;
      end
    endcase
  end

  led_eff_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_DIV),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // result produced by this operation
  always_comb begin
    push     = 1'b0;
    push_res = '0;
    push_res.id = sel8[2:0];
    case (cmd.op)
      OP_CMD: begin
        if (req_q == REQ_MARQUEE) begin
          push = 1'b1;
          push_res.id = 3'd0;
          push_res.lit = 1'b1;
          push_res.level = 7'd100;
          push_res.ann = 1'b1;
          push_res.cause = req_q;
        end else if (idx_bad) begin
          push = 1'b1;
          push_res.id = 3'd0;
          push_res.cause = req_q;
          push_res.bad = 1'b1;
        end else if (req_q == REQ_BLINK || t_off) begin
          push = 1'b1;
          push_res.ann = 1'b1;
          push_res.cause = req_q;
        end else if (t_on) begin
          push = 1'b1;
          push_res.lit = 1'b1;
          push_res.level = 7'd100;
          push_res.ann = 1'b1;
          push_res.cause = req_q;
        end
      end
      OP_BREATHE: begin
        push = 1'b1;
        push_res.ann = 1'b1;
        push_res.cause = req_q;
      end
      OP_FIRE_BLINK: begin
        push = 1'b1;
        push_res.lit = !cur_drive;
        push_res.level = cur_drive ? 7'd0 : 7'd100;
      end
      OP_FIRE_HW: begin
        push = 1'b1;
        push_res.lit = lvl != 7'd0;
        push_res.level = lvl;
      end
      OP_FIRE_OFF: push = 1'b1;
      OP_FIRE_ON: begin
        push = 1'b1;
        push_res.lit = (on_q != 16'd0) || cur_drive;
        push_res.level = push_res.lit ? 7'd100 : 7'd0;
      end
      OP_MARQ_TICK: begin
        push = mq_fire;
        push_res.id = 3'(8'(mq_next));
        push_res.lit = 1'b1;
        push_res.level = 7'd100;
      end
      default: ;
    endcase
  end

  // state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        mode[i]   <= MODE_STATIC;
        period[i] <= '0;
        step[i]   <= '0;
        total[i]  <= '0;
        cd[i]     <= '0;
      end
      mon       <= '0;
      drive     <= '0;
      rising    <= '0;
      onph      <= '0;
      mq_active <= 1'b0;
      mq_pos    <= '0;
      mq_period <= '0;
      mq_cd     <= '0;
      fire_q    <= 1'b0;
      wptr      <= '0;
      rptr      <= '0;
      sel       <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      case (cmd.op)
        OP_LOAD: begin
          req_q <= req_type;
          idx_q <= led_index;
          per_q <= duration_ms;
          sel   <= (req_type == REQ_TICK) ? '0 : led_index[LIDX_W-1:0];
          wptr  <= '0;
          rptr  <= '0;
        end
        OP_CMD: begin
          if (req_q == REQ_MARQUEE) begin
            for (int i = 0; i < LED_COUNT; i++) begin
              mode[i] <= MODE_STATIC;
              cd[i]   <= '0;
            end
            mon       <= '0;
            drive     <= LED_COUNT'(1);
            mq_period <= pe_marq;
            mq_pos    <= '0;
            mq_active <= 1'b1;
            mq_cd     <= arm(pe_marq);
          end else if (!idx_bad) begin
            // stop a running marquee, drop the led's effect
            if (mq_active) begin
              mq_active      <= 1'b0;
              mq_cd          <= '0;
              drive[mq_pos]  <= 1'b0;
            end
            mode[idx_l] <= MODE_STATIC;
            cd[idx_l]   <= '0;
            if (req_q == REQ_BLINK) begin
              mode[idx_l]   <= MODE_BLINK;
              period[idx_l] <= pe_blink;
              drive[idx_l]  <= 1'b0;
              mon[idx_l]    <= 1'b0;
              cd[idx_l]     <= arm(pe_blink);
            end else if (t_on) begin
              mon[idx_l]   <= 1'b1;
              drive[idx_l] <= 1'b1;
            end else if (t_off) begin
              mon[idx_l]   <= 1'b0;
              drive[idx_l] <= 1'b0;
            end
          end
        end
        OP_BREATHE: begin
          if (mq_active) begin
            mq_active     <= 1'b0;
            mq_cd         <= '0;
            drive[mq_pos] <= 1'b0;
          end
          mode[idx_l]   <= MODE_BREATHE;
          period[idx_l] <= pe_breathe;
          step[idx_l]   <= '0;
          total[idx_l]  <= (div_q < DVD_W'(2)) ? 16'd2 : q16;
          rising[idx_l] <= 1'b1;
          onph[idx_l]   <= 1'b0;
          drive[idx_l]  <= 1'b0;
          mon[idx_l]    <= 1'b0;
          cd[idx_l]     <= 16'(frame);
        end
        OP_CHECK: begin
          fire_q <= 1'b0;
          if (cur_mode != MODE_STATIC && cur_cd != 16'd0) begin
            cd[sel] <= cur_cd - 16'd1;
            fire_q  <= cur_cd == 16'd1;
          end
        end
        OP_FIRE_BLINK: begin
          drive[sel] <= !cur_drive;
          cd[sel]    <= arm(cur_period);
        end
        OP_FIRE_HW: begin
          drive[sel]  <= lvl != 7'd0;
          step[sel]   <= adv_step;
          rising[sel] <= adv_rising;
          cd[sel]     <= 16'(frame);
        end
        OP_FIRE_OFF: begin
          drive[sel] <= 1'b0;
          onph[sel]  <= 1'b0;
          cd[sel]    <= arm(q16);
        end
        OP_ADVANCE: begin
          step[sel]   <= adv_step;
          rising[sel] <= adv_rising;
        end
        OP_SAVE_ON: on_q <= q16;
        OP_FIRE_ON: begin
          if (on_q != 16'd0) begin
            drive[sel] <= 1'b1;
            onph[sel]  <= 1'b1;
            cd[sel]    <= arm(on_q);
          end else begin
            cd[sel] <= (q16 != 16'd0) ? q16 : 16'(frame);
          end
        end
        OP_NEXT: sel <= sel + 1'b1;
        OP_MARQ_TICK: begin
          if (mq_active && mq_cd != 16'd0) begin
            mq_cd <= mq_cd - 16'd1;
            if (mq_fire) begin
              drive[mq_pos]  <= 1'b0;
              drive[mq_next] <= 1'b1;
              mq_pos         <= mq_next;
              mq_cd          <= arm(mq_period);
            end
          end
        end
        OP_POP: rptr <= rptr + 1'b1;
        default: ;
      endcase
    end
  end

  // result queue
  res_t qmem [LED_COUNT];

  always_ff @(posedge clk) begin
    if (push) qmem[wptr[LIDX_W-1:0]] <= push_res;
    if (cmd.op == OP_READ) begin
      res      <= qmem[rptr[LIDX_W-1:0]];
      res_last <= (rptr + 1'b1) == wptr;
    end
  end

  // status and drive bits
  always_comb begin
    drive_pad  = {8'd0, drive};
    drive_mask = drive_pad[7:0];
    stat.is_tick    = req_q == REQ_TICK;
    stat.is_breathe = (req_q == REQ_BREATHE) && !idx_bad;
    stat.fire       = fire_q;
    stat.blink      = cur_mode == MODE_BLINK;
    stat.hw         = (sel8 < 8'd8) && hw_mask[sel8[2:0]];
    stat.onph       = cur_onph;
    stat.walk_last  = sel == LIDX_W'(LED_COUNT - 1);
    stat.q_empty    = rptr == wptr;
    stat.div_done   = div_done;
  end

endmodule

// ----- rtl/led_eff_ctrl.sv -----
// controller: sequences one request through the datapath and drains its results
module led_eff_ctrl
  import led_eff_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     res_last,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DECODE = 14'b00000000000010,
    S_BRW    = 14'b00000000000100,
    S_CHECK  = 14'b00000000001000,
    S_FIRE   = 14'b00000000010000,
    S_HWW    = 14'b00000000100000,
    S_OFFW   = 14'b00000001000000,
    S_DON    = 14'b00000010000000,
    S_ONW    = 14'b00000100000000,
    S_DOFF   = 14'b00001000000000,
    S_OFF2W  = 14'b00010000000000,
    S_NEXT   = 14'b00100000000000,
    S_RD     = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.sel    = DIV_STEPS;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_tick) begin
          state_next = S_CHECK;
        end else if (stat.is_breathe) begin
          cmd.op     = OP_DIV;
          cmd.sel    = DIV_STEPS;
          state_next = S_BRW;
        end else begin
          cmd.op     = OP_CMD;
          state_next = S_RD;
        end
      end
      S_BRW: begin
        if (stat.div_done) begin
          cmd.op     = OP_BREATHE;
          state_next = S_RD;
        end
      end
      S_CHECK: begin
        cmd.op     = OP_CHECK;
        state_next = S_FIRE;
      end
      S_FIRE: begin
        if (!stat.fire) begin
          state_next = S_NEXT;
        end else if (stat.blink) begin
          cmd.op     = OP_FIRE_BLINK;
          state_next = S_NEXT;
        end else if (stat.hw) begin
          cmd.op     = OP_DIV;
          cmd.sel    = DIV_LEVEL;
          state_next = S_HWW;
        end else if (stat.onph) begin
          cmd.op     = OP_DIV;
          cmd.sel    = DIV_OFF;
          state_next = S_OFFW;
        end else begin
          cmd.op     = OP_ADVANCE;
          state_next = S_DON;
        end
      end
      S_HWW: begin
        if (stat.div_done) begin
          cmd.op     = OP_FIRE_HW;
          state_next = S_NEXT;
        end
      end
      S_OFFW: begin
        if (stat.div_done) begin
          cmd.op     = OP_FIRE_OFF;
          state_next = S_NEXT;
        end
      end
      S_DON: begin
        cmd.op     = OP_DIV;
        cmd.sel    = DIV_ON;
        state_next = S_ONW;
      end
      S_ONW: begin
        if (stat.div_done) begin
          cmd.op     = OP_SAVE_ON;
          state_next = S_DOFF;
        end
      end
      S_DOFF: begin
        cmd.op     = OP_DIV;
        cmd.sel    = DIV_OFF;
        state_next = S_OFF2W;
      end
      S_OFF2W: begin
        if (stat.div_done) begin
          cmd.op     = OP_FIRE_ON;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (stat.walk_last) begin
          cmd.op     = OP_MARQ_TICK;
          state_next = S_RD;
        end else begin
          cmd.op     = OP_NEXT;
          state_next = S_CHECK;
        end
      end
      S_RD: begin
        if (stat.q_empty) begin
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_READ;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.op     = OP_POP;
          state_next = res_last ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
